// ===== rtl/core/des_round_function_defines.svh =====
// Assertion macros for the DES round function.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef DES_ROUND_FUNCTION_DEFINES_SVH
`define DES_ROUND_FUNCTION_DEFINES_SVH

// Same-cycle implication.
`define DESRF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication.
`define DESRF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/desrf_pkg.sv =====
package desrf_pkg;

	localparam int unsigned IN_BITS  = 32;
	localparam int unsigned EXP_BITS = 48;
	localparam int unsigned BOXES    = 8;

	typedef logic [IN_BITS-1:0]  word_t;
	typedef logic [EXP_BITS-1:0] exp_word_t;

	// Expansion selection: entry i names the source bit (1 = MSB) of output bit i+1.
	localparam logic [5:0] E_SEL [0:EXP_BITS-1] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	// Output permutation: entry i names the source bit (1 = MSB) of output bit i+1.
	localparam logic [5:0] P_SEL [0:IN_BITS-1] = '{
		6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
	};

	// The eight standard substitution boxes, indexed [box][row][column].
	localparam logic [3:0] SBOX_TAB [0:BOXES-1][0:3][0:15] = '{
		'{ '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
		     4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
		   '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
		     4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
		   '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
		     4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
		   '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
		     4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13} },
		'{ '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
		     4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
		   '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
		     4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
		   '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
		     4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
		   '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
		     4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9} },
		'{ '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
		     4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
		   '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
		     4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
		   '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
		     4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
		   '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
		     4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12} },
		'{ '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
		     4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
		   '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
		     4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
		   '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
		     4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
		   '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
		     4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14} },
		'{ '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
		     4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
		   '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
		     4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
		   '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
		     4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
		   '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
		     4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3} },
		'{ '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
		     4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
		   '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
		     4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
		   '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
		     4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
		   '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
		     4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13} },
		'{ '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
		     4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
		   '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
		     4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
		   '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
		     4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
		   '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
		     4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12} },
		'{ '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
		     4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
		   '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
		     4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
		   '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
		     4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
		   '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
		     4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11} }
	};

	// E expansion of the right half; bit 1 is the MSB on both sides.
	function automatic exp_word_t expand(input word_t r);
		exp_word_t acc;
		acc = '0;
		for (int i = 0; i < EXP_BITS; i++) begin
			acc[EXP_BITS-1-i] = r[IN_BITS - int'(E_SEL[i])];
		end
		return acc;
	endfunction

	// Eight parallel S-box lookups; group 0 sits at the MSB end and feeds S1.
	function automatic word_t sbox_layer(input exp_word_t x);
		word_t      acc;
		logic [5:0] grp;
		logic [1:0] row;
		logic [3:0] col;
		acc = '0;
		for (int n = 0; n < BOXES; n++) begin
			grp = x[EXP_BITS-1-6*n -: 6];
			row = {grp[5], grp[0]};
			col = grp[4:1];
			acc[IN_BITS-1-4*n -: 4] = SBOX_TAB[n][row][col];
		end
		return acc;
	endfunction

	// P permutation of the S-box output word.
	function automatic word_t permute(input word_t s);
		word_t acc;
		acc = '0;
		for (int i = 0; i < IN_BITS; i++) begin
			acc[IN_BITS-1-i] = s[IN_BITS - int'(P_SEL[i])];
		end
		return acc;
	endfunction

endpackage

// ===== rtl/core/desrf_expand.sv =====
module desrf_expand (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  desrf_pkg::word_t         right_half,
	input  desrf_pkg::exp_word_t     round_key,
	input  logic                     down_ready,
	output logic                     ready,
	output logic                     valid_s1,
	output desrf_pkg::exp_word_t     mixed_s1
);

	// The stage takes a new item when it is empty or its item moves on.
	assign ready = !valid_s1 || down_ready;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Expand the right half and mix in the round key.
	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			mixed_s1 <= desrf_pkg::expand(right_half) ^ round_key;
		end
	end

endmodule

// ===== rtl/core/desrf_sbox.sv =====
module desrf_sbox (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	input  desrf_pkg::exp_word_t     mixed,
	input  logic                     down_ready,
	output logic                     ready,
	output logic                     valid_s2,
	output desrf_pkg::word_t         subst_s2
);

	// The stage takes a new item when it is empty or its item moves on.
	assign ready = !valid_s2 || down_ready;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= up_valid;
		end
	end

	// Eight S-box lookups in parallel.
	always_ff @(posedge clk) begin
		if (ready && up_valid) begin
			subst_s2 <= desrf_pkg::sbox_layer(mixed);
		end
	end

endmodule

// ===== rtl/core/desrf_permute.sv =====
module desrf_permute (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	input  desrf_pkg::word_t         subst,
	input  logic                     out_stall,
	output logic                     ready,
	output logic                     valid_s3,
	output desrf_pkg::word_t         f_value_s3
);

	// The output register frees up when it is empty or its item is taken.
	assign ready = !valid_s3 || !out_stall;

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready) begin
			valid_s3 <= up_valid;
		end
	end

	// Apply the P permutation into the output register.
	always_ff @(posedge clk) begin
		if (ready && up_valid) begin
			f_value_s3 <= desrf_pkg::permute(subst);
		end
	end

endmodule

// ===== rtl/core/des_round_function.sv =====
// DES round function f(R, K) = P(S(E(R) xor K)).
//
// Input channel: in_valid / in_stall carry one item of right_half (32 bits)
// and round_key (48 bits). An item is taken at a clock edge with in_valid high
// and in_stall low.
// Output channel: out_valid / out_stall carry f_value (32 bits), one item per
// input item, in input order.
//
// Expansion and key mix, S-box lookup and permutation each end in a register.
// Throughput is one item per cycle while out_stall stays low; the three
// stages overlap fully.
// When the receiver raises out_stall, the output holds its item and value.
// Empty stages still fill behind it; in_stall rises only once all three
// stages hold items. No item is dropped or repeated.
// Reset (arst_n low) empties the pipeline; the block keeps no other state.
`include "des_round_function_defines.svh"

module des_round_function (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  desrf_pkg::word_t         right_half,
	input  desrf_pkg::exp_word_t     round_key,
	output logic                     out_valid,
	input  logic                     out_stall,
	output desrf_pkg::word_t         f_value
);

	logic                 ready_1;
	logic                 ready_2;
	logic                 ready_3;
	logic                 valid_s1;
	logic                 valid_s2;
	desrf_pkg::exp_word_t mixed_s1;
	desrf_pkg::word_t     subst_s2;

	// Stage one: expansion and key mix.
	desrf_expand u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.right_half (right_half),
		.round_key  (round_key),
		.down_ready (ready_2),
		.ready      (ready_1),
		.valid_s1   (valid_s1),
		.mixed_s1   (mixed_s1)
	);

	// Stage two: substitution.
	desrf_sbox u_sbox (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s1),
		.mixed      (mixed_s1),
		.down_ready (ready_3),
		.ready      (ready_2),
		.valid_s2   (valid_s2),
		.subst_s2   (subst_s2)
	);

	// Stage three: permutation into the output register.
	desrf_permute u_permute (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s2),
		.subst      (subst_s2),
		.out_stall  (out_stall),
		.ready      (ready_3),
		.valid_s3   (out_valid),
		.f_value_s3 (f_value)
	);

	assign in_stall = !ready_1;

	// The input stalls only when every stage is full and the output is held.
	`DESRF_ASSERT_IMP(a_stall_only_when_full, in_stall,
		valid_s1 && valid_s2 && out_valid && out_stall)

	// An accepted item always lands in stage one.
	`DESRF_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, valid_s1)

	// A stage-two item moves to the output whenever the output is free.
	`DESRF_ASSERT_NEXT(a_s2_advances, valid_s2 && (!out_valid || !out_stall), out_valid)

	// A stage-one item never vanishes: it either stays or moves to stage two.
	`DESRF_ASSERT_NEXT(a_s1_kept, valid_s1, valid_s1 || valid_s2)

endmodule
